// ----- hw/rtl/itoa_pkg.sv -----
// shared constants and helpers for the signed integer to decimal text core
package itoa_pkg;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // binary bits folded into the bcd register per conversion cycle
  localparam int unsigned DD_BITS = 4;

  // double dabble correction of one bcd digit
  function automatic logic [3:0] add3(input logic [3:0] dig);
    return (dig >= 4'd5) ? (dig + 4'd3) : dig;
  endfunction

endpackage

// ----- hw/rtl/signed_int_to_decimal_ascii_core.sv -----
// top level: signed integer to decimal ascii text converter
// Usage:
//   Input channel (in_valid_i / in_ready_o / value_i) takes one two's
//   complement word of VALUE_BITS bits. Output channel (out_valid_o /
//   out_ready_i) returns its decimal text, one ascii character per word:
//   an optional '-', then the digits most significant first, no leading
//   zeros, is_last_o high on the final character.
//   The front converts the magnitude to bcd with a double dabble unit that
//   folds 4 bits a cycle, and takes a new input only after its last word
//   has entered the queue. A two-entry queue decouples it from the emitter,
//   which sends one character a cycle while the receiver is ready.
//   A word passes through the front's conversion, the queue and the
//   emitter's output register before its first character appears.
//   When the receiver stalls, the character is held in the output register
//   and the queue fills; the input stalls once both queue slots are full
//   and the front holds a converted word.
//   Reset empties the queue and returns both parts to idle; no state is
//   carried from one input to the next.
module signed_int_to_decimal_ascii_core import itoa_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   text_char_o,
  output logic                         is_last_o
);

  // decimal digits needed for the widest magnitude
  localparam int unsigned NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned WORD_W = 4 * NDIG + 1;

  logic              fq_valid, fq_ready;
  logic [WORD_W-1:0] fq_data;
  logic              qb_valid, qb_ready;
  logic [WORD_W-1:0] qb_data;

  itoa_front #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .value_i   (value_i),
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_data_o  (fq_data)
  );

  itoa_queue #(
    .WIDTH(WORD_W),
    .DEPTH(2)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fq_valid),
    .wr_ready_o(fq_ready),
    .wr_data_i (fq_data),
    .rd_valid_o(qb_valid),
    .rd_ready_i(qb_ready),
    .rd_data_o (qb_data)
  );

  itoa_back #(
    .NDIG(NDIG)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (qb_valid),
    .q_ready_o  (qb_ready),
    .q_data_i   (qb_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .text_char_o(text_char_o),
    .is_last_o  (is_last_o)
  );

endmodule

// ----- hw/rtl/itoa_front.sv -----
// front part: accepts a word, forms sign and magnitude, converts to bcd
module itoa_front import itoa_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned NDIG       = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         q_valid_o,
  input  logic                         q_ready_i,
  output logic [4*NDIG:0]              q_data_o
);

  localparam int unsigned STEPS = (VALUE_BITS + DD_BITS - 1) / DD_BITS;
  localparam int unsigned SH_W  = STEPS * DD_BITS;
  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_DONE = 3'b100
  } front_state_e;

  front_state_e      state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [SH_W-1:0]   shift_q, shift_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [SH_W-1:0]       sh_step;
  logic [BCD_W-1:0]      bcd_step;

  // magnitude of the incoming word, most negative value wraps to its true size
  assign raw = value_i;
  assign mag = raw[VALUE_BITS-1] ? ({VALUE_BITS{1'b0}} - raw) : raw;

  // one conversion cycle: several double dabble bit steps
  always_comb begin
    bcd_step = bcd_q;
    sh_step  = shift_q;
    for (int s = 0; s < DD_BITS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        bcd_step[d*4 +: 4] = add3(bcd_step[d*4 +: 4]);
      end
      bcd_step = {bcd_step[BCD_W-2:0], sh_step[SH_W-1]};
      sh_step  = {sh_step[SH_W-2:0], 1'b0};
    end
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign q_valid_o  = (state_q == F_DONE);
  assign q_data_o   = {neg_q, bcd_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    shift_d = shift_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = F_CONV;
          cnt_d   = CNT_W'(STEPS);
          neg_d   = raw[VALUE_BITS-1];
          shift_d = (SH_W)'(mag);
          bcd_d   = '0;
        end
      end
      F_CONV: begin
        shift_d = sh_step;
        bcd_d   = bcd_step;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = F_DONE;
        end
      end
      F_DONE: begin
        if (q_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
  end

endmodule

// ----- hw/rtl/itoa_queue.sv -----
// short word queue between the converter and the character emitter
module itoa_queue #(
  parameter int unsigned WIDTH = 41,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hw/rtl/itoa_back.sv -----
// back part: emits sign and digits of one converted word, one character a cycle while the receiver is ready
module itoa_back import itoa_pkg::*; #(
  parameter int unsigned NDIG = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  logic [4*NDIG:0]   q_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        text_char_o,
  output logic              is_last_o
);

  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned IDX_W = $clog2(NDIG);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SIGN  = 3'b010,
    B_DIGIT = 3'b100
  } back_state_e;

  back_state_e      state_q, state_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;

  logic             out_free;
  logic             last_emit;
  logic             load;
  logic [IDX_W-1:0] top_idx;
  logic [3:0]       cur_dig;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_emit = (state_q == B_DIGIT) && out_free && (idx_q == '0);
  assign q_ready_o = (state_q == B_IDLE) || last_emit;
  assign load      = q_valid_i && q_ready_o;
  assign cur_dig   = bcd_q[idx_q*4 +: 4];

  // highest nonzero digit, zero shows as a single digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (q_data_i[d*4 +: 4] != 4'd0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  // emitter sequencer and output register
  always_comb begin
    state_d     = state_q;
    bcd_d       = bcd_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      B_IDLE: ;
      B_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_ZERO + {4'd0, cur_dig};
          last_d      = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = B_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
    // next word enters while idle or as the previous run closes
    if (load) begin
      bcd_d   = q_data_i[BCD_W-1:0];
      idx_d   = top_idx;
      state_d = q_data_i[BCD_W] ? B_SIGN : B_DIGIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign is_last_o   = last_q;

endmodule

// ----- bench/itoa_text_checker.sv -----
// channel monitor, text predictor and scoreboard for the decimal ascii core
`timescale 1ns / 1ps

module itoa_text_checker import itoa_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [7:0]                   text_char_i,
  input  logic                         is_last_i,
  output int                           mismatch_count_o,
  output int                           chars_pending_o
);

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } text_word_t;

  // characters still owed by the core, oldest first
  text_word_t expected_text[$];
  int         mismatch_count = 0;
  int         chars_pending  = 0;

  assign mismatch_count_o = mismatch_count;
  assign chars_pending_o  = chars_pending;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch: %s got 0x%02h want 0x%02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // decimal text of one value: optional minus, digits msd first
  function automatic void queue_decimal_text(input logic signed [VALUE_BITS-1:0] value);
    logic [VALUE_BITS:0] magnitude;
    logic [7:0]          digits[24];
    int                  n_digits;
    text_word_t          w;
    n_digits  = 0;
    // one extra bit so the most negative value keeps its full magnitude
    magnitude = value[VALUE_BITS-1] ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
    do begin
      digits[n_digits] = CHAR_ZERO + 8'(magnitude % 10);
      n_digits++;
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (value[VALUE_BITS-1]) begin
      w.text_char = CHAR_MINUS;
      w.is_last   = 1'b0;
      expected_text.push_back(w);
    end
    for (int k = n_digits - 1; k >= 0; k--) begin
      w.text_char = digits[k];
      w.is_last   = (k == 0);
      expected_text.push_back(w);
    end
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    text_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        queue_decimal_text(value_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected word", text_char_i, 8'h00);
        end else begin
          want = expected_text.pop_front();
          if (text_char_i !== want.text_char) begin
            report_mismatch("text_char", text_char_i, want.text_char);
          end
          if (is_last_i !== want.is_last) begin
            report_mismatch("is_last", {7'd0, is_last_i}, {7'd0, want.is_last});
          end
        end
      end
      chars_pending = expected_text.size();
    end
  end

endmodule

// ----- bench/tb_signed_int_to_decimal_ascii_core.sv -----
// top of the decimal ascii core testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_core;

  localparam int unsigned VALUE_BITS = 32;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   text_char;
  logic                         is_last;
  int                           mismatch_count;
  int                           chars_pending;

  // idling on both sides is switched per phase
  bit gaps_on = 1'b1;
  int stall_left = 0;

  // extremes, digit-count boundaries and sign cases
  int directed_values[22] = '{
    0, 1, -1, 9, 10, -9, -10, 99, 100, -100,
    32'h7fffffff, 32'h80000000, 32'h80000001, 2147483646,
    1000000000, 999999999, -999999999, -1000000000,
    123456789, -123456789, 32'h55555555, 32'haaaaaaaa
  };

  always #4 clk_i = ~clk_i;

  signed_int_to_decimal_ascii_core #(
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .text_char_o (text_char),
    .is_last_o   (is_last)
  );

  itoa_text_checker #(
    .VALUE_BITS (VALUE_BITS)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .text_char_i      (text_char),
    .is_last_i        (is_last),
    .mismatch_count_o (mismatch_count),
    .chars_pending_o  (chars_pending)
  );

  // receiver back-pressure in bursts, started at random while gaps are on
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready  = 1'b0;
      stall_left = stall_left - 1;
    end else if (gaps_on && rst_ni && $urandom_range(0, 5) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_ready  = 1'b1;
    end
  end

  // offer one word, called and returning at a falling edge
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    value    = v;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // random value, mostly spread evenly over the decimal lengths
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int              n_digits;
    int              mode;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      return $urandom;
    end else if (mode < 9) begin
      n_digits = $urandom_range(1, 10);
      lo = 1;
      for (int k = 1; k < n_digits; k++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (n_digits == 1) lo = 0;
      if (hi > 64'd2147483647) hi = 64'd2147483647;
      mag = lo + ($urandom % (hi - lo + 1));
      return $urandom_range(0, 1) ? -mag[VALUE_BITS-1:0] : mag[VALUE_BITS-1:0];
    end else begin
      // near the extremes and the powers of ten
      case ($urandom_range(0, 2))
        0: return 32'h7fffffff - $urandom_range(0, 3);
        1: return 32'h80000000 + $urandom_range(0, 3);
        default: begin
          mag = 1;
          repeat ($urandom_range(0, 9)) mag = mag * 10;
          mag = mag + $urandom_range(0, 2) - 1;
          return $urandom_range(0, 1) ? -mag[VALUE_BITS-1:0] : mag[VALUE_BITS-1:0];
        end
      endcase
    end
  endfunction

  // stimulus and verdict
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed_values[i]) send_value(directed_values[i]);
    repeat (98) send_value(pick_value());
    // stretch with no idling in the middle
    gaps_on = 1'b0;
    repeat (50) send_value(pick_value());
    gaps_on = 1'b1;
    repeat (70) send_value(pick_value());
    // final part runs without idling
    gaps_on = 1'b0;
    repeat (30) send_value(pick_value());
    in_valid = 1'b0;
    wait (chars_pending == 0);
    repeat (24) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_front.sv
hw/rtl/itoa_queue.sv
hw/rtl/itoa_back.sv
hw/rtl/signed_int_to_decimal_ascii_core.sv
bench/itoa_text_checker.sv
bench/tb_signed_int_to_decimal_ascii_core.sv
